/* hdl/kf3_pkg.sv */
// Types and codes shared by the three-state Kalman filter modules.
package kf3_pkg;

  // Configuration port geometry.
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 64;

  // Register indexes on the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_A_ROW_0    = 3'd0,
    CFG_A_ROW_1    = 3'd1,
    CFG_A_ROW_2    = 3'd2,
    CFG_B_AND_Q    = 3'd3,
    CFG_H_AND_R    = 3'd4,
    CFG_P0_UPPER_A = 3'd5,
    CFG_P0_UPPER_B = 3'd6
  } cfg_idx_e;

  // Operation codes carried by the mode field.
  typedef enum logic [2:0] {
    MODE_PREDICT     = 3'd0,
    MODE_CORRECT     = 3'd1,
    MODE_INIT_VALUES = 3'd2,
    MODE_INIT_ZERO   = 3'd3,
    MODE_SET_THIRD   = 3'd4,
    MODE_BASE        = 3'd5
  } mode_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOT_INIT = 2'd1,
    ST_SINGULAR = 2'd2
  } status_e;

  // Dot-product phases of the multiply-accumulate sequence.
  typedef enum logic [2:0] {
    PH_XP,  // predicted state
    PH_T,   // A P
    PH_PP,  // (A P) A^T + Q
    PH_V,   // P' H^T
    PH_U,   // H P'
    PH_S,   // innovation variance
    PH_HX   // predicted measurement
  } phase_e;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_MAC,
    S_DRAIN,
    S_COMMIT,
    S_CHECK,
    S_DMUL,
    S_DSTART,
    S_DWAIT,
    S_DWB,
    S_FIN
  } kf3_state_e;

  // Input item.
  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] first_value;
    logic signed [31:0] second_value;
    logic signed [31:0] third_value;
  } kf3_in_t;

  // Result item.
  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] estimate_0;
    logic signed [31:0] estimate_1;
    logic signed [31:0] estimate_2;
  } kf3_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       capture;    // latch the input item
    logic       simple;     // apply an initialise, set-third or base operation
    logic       mac;        // issue one multiply-accumulate term
    phase_e     phase;
    logic [1:0] i;
    logic [1:0] j;
    logic [1:0] k;
    logic       first;      // first term of a dot product
    logic       last;       // last term of a dot product
    logic       commit;     // copy the predicted state into the estimate
    logic       calc_e;     // form the innovation
    logic       div_sel;    // 0: state update, 1: covariance update
    logic       div_mul;    // form the dividend
    logic       div_start;  // launch the divider
    logic       div_wb;     // write back the updated entry
    logic       out_load;   // load the result register
    status_e    status;
  } kf3_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] mode;
    logic       s_zero;
    logic       div_done;
    logic       out_busy;
  } kf3_sts_t;

endpackage

/* hdl/kf3_div.sv */
// Bit-serial signed divider, quotient truncated toward zero.
module kf3_div
  import kf3_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] num_i,
  input  logic signed [31:0] den_i,
  output logic               done_o,
  output logic signed [63:0] quot_o
);

  localparam int DivSteps = 64;
  localparam int CntW     = $clog2(DivSteps);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [31:0]     rem_q;
  logic [63:0]     quo_q;
  logic [31:0]     dmag_q;
  logic            neg_q;

  logic [63:0] nmag;
  logic [31:0] dmag;
  logic [32:0] trial;
  logic        ge;
  logic [32:0] diff;

  // Operand magnitudes and one restoring step.
  always_comb begin
    nmag  = num_i[63] ? (~num_i + 64'd1) : num_i;
    dmag  = den_i[31] ? (~den_i + 32'd1) : den_i;
    trial = {rem_q, quo_q[63]};
    ge    = (trial >= {1'b0, dmag_q});
    diff  = trial - {1'b0, dmag_q};
  end

  // Sequencing of the iterations.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(DivSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift register.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      quo_q  <= nmag;
      dmag_q <= dmag;
      neg_q  <= num_i[63] ^ den_i[31];
    end else if (busy_q) begin
      rem_q <= ge ? diff[31:0] : trial[31:0];
      quo_q <= {quo_q[62:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? -$signed(quo_q) : $signed(quo_q);

`ifndef ASSERT_OFF
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");
`endif

endmodule

/* hdl/kf3_dp.sv */
// Datapath: configuration, state, multiply-accumulate unit, divider and result register.
module kf3_dp
  import kf3_pkg::*;
#(
  parameter int STATE_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  kf3_in_t             in_data_i,
  output kf3_out_t            out_data_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  kf3_cmd_t            cmd_i,
  output kf3_sts_t            sts_o
);

  localparam int W    = STATE_WIDTH;
  localparam int OPW  = (W > 32) ? W : 32;
  localparam int ACCW = OPW + 6;
  localparam int PRODW = OPW + 16;
  localparam int XW   = 66;

  // Saturate a wide value to the state width.
  function automatic logic signed [W-1:0] sat_w(input logic signed [XW-1:0] a);
    if ((&a[XW-1:W-1]) || !(|a[XW-1:W-1])) return a[W-1:0];
    else if (a[XW-1]) return {1'b1, {(W-1){1'b0}}};
    else return {1'b0, {(W-1){1'b1}}};
  endfunction

  // Saturate a wide value to 32 bits.
  function automatic logic signed [31:0] sat_32(input logic signed [XW-1:0] a);
    if ((&a[XW-1:31]) || !(|a[XW-1:31])) return a[31:0];
    else if (a[XW-1]) return {1'b1, {31{1'b0}}};
    else return {1'b0, {31{1'b1}}};
  endfunction

  // Row-major index into a 3x3 matrix.
  function automatic logic [3:0] idx3(input logic [1:0] r, input logic [1:0] c);
    return {1'b0, r, 1'b0} + {2'b00, r} + {2'b00, c};
  endfunction

  // Q4.12 coefficient raised to Q16.16.
  function automatic logic signed [W-1:0] p0w(input logic [15:0] w);
    return W'($signed({w, 4'b0000}));
  endfunction

  // Configuration registers.
  logic [47:0] a_row_q [3];
  logic [63:0] bq_q;
  logic [63:0] hr_q;
  logic [63:0] p0a_q;
  logic [31:0] p0b_q;

  // Filter state and scratch.
  logic signed [W-1:0]    x_q  [3];
  logic signed [W-1:0]    p_q  [9];
  logic signed [W-1:0]    t_q  [9];
  logic signed [W-1:0]    pp_q [9];
  logic signed [W-1:0]    xp_q [3];
  logic signed [31:0]     v_q  [3];
  logic signed [31:0]     u_q  [3];
  logic signed [31:0]     s_q;
  logic signed [ACCW-1:0] hx_q;
  logic signed [31:0]     e_q;
  kf3_in_t                in_q;

  // Multiply-accumulate pipeline.
  logic signed [15:0]     coef;
  logic signed [OPW-1:0]  opnd;
  logic signed [ACCW-1:0] init_d;
  logic signed [PRODW-1:0] prod_q;
  logic signed [ACCW-1:0] init_q;
  logic signed [ACCW-1:0] acc_q;
  logic signed [ACCW-1:0] acc_next;
  logic                   mac_q;
  logic                   first_q;
  logic                   last_q;
  phase_e                 phase_q;
  logic [1:0]             di_q;
  logic [1:0]             dj_q;
  logic [3:0]             pp_rd;

  // Division operands and write-back.
  logic signed [63:0] dprod_q;
  logic signed [63:0] quot;
  logic               div_done;
  logic signed [W-1:0] wb_base;
  logic signed [W-1:0] wb_val;

  // Result register.
  logic     out_valid_q;
  kf3_out_t out_q;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_row_q[0] <= '0;
      a_row_q[1] <= '0;
      a_row_q[2] <= '0;
      bq_q       <= '0;
      hr_q       <= '0;
      p0a_q      <= '0;
      p0b_q      <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_A_ROW_0:    a_row_q[0] <= cfg_data_i[47:0];
        CFG_A_ROW_1:    a_row_q[1] <= cfg_data_i[47:0];
        CFG_A_ROW_2:    a_row_q[2] <= cfg_data_i[47:0];
        CFG_B_AND_Q:    bq_q       <= cfg_data_i;
        CFG_H_AND_R:    hr_q       <= cfg_data_i;
        CFG_P0_UPPER_A: p0a_q      <= cfg_data_i;
        CFG_P0_UPPER_B: p0b_q      <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // Coefficient, operand and starting value for the current term.
  always_comb begin
    coef   = '0;
    opnd   = '0;
    init_d = '0;
    pp_rd  = idx3(cmd_i.i, cmd_i.j);
    unique case (cmd_i.phase)
      PH_XP: begin
        coef   = a_row_q[cmd_i.i][{cmd_i.k, 4'b0000} +: 16];
        opnd   = OPW'(x_q[cmd_i.k]);
        init_d = ACCW'($signed({bq_q[{cmd_i.i, 4'b0000} +: 16], 4'b0000}));
      end
      PH_T: begin
        coef = a_row_q[cmd_i.i][{cmd_i.k, 4'b0000} +: 16];
        opnd = OPW'(p_q[idx3(cmd_i.k, cmd_i.j)]);
      end
      PH_PP: begin
        coef = a_row_q[cmd_i.j][{cmd_i.k, 4'b0000} +: 16];
        opnd = OPW'(t_q[idx3(cmd_i.i, cmd_i.k)]);
        if (cmd_i.i != 2'd2 && cmd_i.j != 2'd2) begin
          init_d = ACCW'($signed({bq_q[63:48], 4'b0000}));
        end
      end
      PH_V: begin
        pp_rd = idx3(cmd_i.i, cmd_i.k);
        coef  = hr_q[{cmd_i.k, 4'b0000} +: 16];
        opnd  = OPW'(pp_q[pp_rd]);
      end
      PH_U: begin
        pp_rd = idx3(cmd_i.k, cmd_i.i);
        coef  = hr_q[{cmd_i.k, 4'b0000} +: 16];
        opnd  = OPW'(pp_q[pp_rd]);
      end
      PH_S: begin
        coef   = hr_q[{cmd_i.k, 4'b0000} +: 16];
        opnd   = OPW'(v_q[cmd_i.k]);
        init_d = ACCW'($signed({hr_q[63:48], 4'b0000}));
      end
      PH_HX: begin
        coef = hr_q[{cmd_i.k, 4'b0000} +: 16];
        opnd = OPW'(xp_q[cmd_i.k]);
      end
      default: ;
    endcase
  end

  // Each product is floored by the arithmetic shift before it is summed.
  assign acc_next = (first_q ? init_q : acc_q) + ACCW'(prod_q >>> 12);

  // Control of the accumulator pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mac_q   <= 1'b0;
      first_q <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      mac_q   <= cmd_i.mac;
      first_q <= cmd_i.first;
      last_q  <= cmd_i.mac & cmd_i.last;
    end
  end

  // Product, accumulator and stores of finished dot products.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mac) begin
      prod_q  <= PRODW'(coef) * PRODW'(opnd);
      init_q  <= init_d;
      phase_q <= cmd_i.phase;
      di_q    <= cmd_i.i;
      dj_q    <= cmd_i.j;
    end
    if (mac_q) begin
      acc_q <= acc_next;
    end
    if (last_q) begin
      unique case (phase_q)
        PH_XP: xp_q[di_q]            <= sat_w(XW'(acc_next));
        PH_T:  t_q[idx3(di_q, dj_q)]  <= sat_w(XW'(acc_next));
        PH_PP: pp_q[idx3(di_q, dj_q)] <= sat_w(XW'(acc_next));
        PH_V:  v_q[di_q]             <= sat_32(XW'(acc_next));
        PH_U:  u_q[di_q]             <= sat_32(XW'(acc_next));
        PH_S:  s_q                   <= sat_32(XW'(acc_next));
        PH_HX: hx_q                  <= acc_next;
        default: ;
      endcase
    end
  end

  // Input item, innovation and dividend.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_q <= in_data_i;
    end
    if (cmd_i.calc_e) begin
      e_q <= sat_32(XW'($signed(in_q.first_value)) - XW'(hx_q));
    end
    if (cmd_i.div_mul) begin
      dprod_q <= 64'(v_q[cmd_i.i]) * (cmd_i.div_sel ? 64'(u_q[cmd_i.j]) : 64'(e_q));
    end
  end

  kf3_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (dprod_q),
    .den_i   (s_q),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // Updated entry: a state entry gains the quotient, a covariance entry loses
  // it; either is saturated.
  always_comb begin
    wb_base = cmd_i.div_sel ? pp_q[pp_rd] : xp_q[cmd_i.i];
    wb_val  = cmd_i.div_sel ? sat_w(XW'(wb_base) - XW'(quot))
                            : sat_w(XW'(wb_base) + XW'(quot));
  end

  // Estimate register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q[0] <= '0;
      x_q[1] <= '0;
      x_q[2] <= '0;
    end else if (cmd_i.simple) begin
      unique case (in_q.mode)
        MODE_INIT_VALUES: begin
          x_q[0] <= sat_w(XW'($signed(in_q.first_value)));
          x_q[1] <= sat_w(XW'($signed(in_q.second_value)));
          x_q[2] <= sat_w(XW'($signed(in_q.third_value)));
        end
        MODE_INIT_ZERO: begin
          x_q[0] <= '0;
          x_q[1] <= '0;
          x_q[2] <= '0;
        end
        MODE_SET_THIRD: x_q[2] <= sat_w(XW'($signed(in_q.third_value)));
        MODE_BASE: x_q[0] <= sat_w(XW'(x_q[0]) - (XW'($signed(in_q.first_value)) <<< 16));
        default: ;
      endcase
    end else if (cmd_i.commit) begin
      x_q[0] <= xp_q[0];
      x_q[1] <= xp_q[1];
      x_q[2] <= xp_q[2];
    end else if (cmd_i.div_wb && !cmd_i.div_sel) begin
      x_q[cmd_i.i] <= wb_val;
    end
  end

  // Covariance: loaded symmetric from P0, updated one entry per division.
  always_ff @(posedge clk_i) begin
    if (cmd_i.simple &&
        (in_q.mode == MODE_INIT_VALUES || in_q.mode == MODE_INIT_ZERO)) begin
      p_q[0] <= p0w(p0a_q[15:0]);
      p_q[1] <= p0w(p0a_q[31:16]);
      p_q[2] <= p0w(p0a_q[47:32]);
      p_q[3] <= p0w(p0a_q[31:16]);
      p_q[4] <= p0w(p0a_q[63:48]);
      p_q[5] <= p0w(p0b_q[15:0]);
      p_q[6] <= p0w(p0a_q[47:32]);
      p_q[7] <= p0w(p0b_q[15:0]);
      p_q[8] <= p0w(p0b_q[31:16]);
    end else if (cmd_i.div_wb && cmd_i.div_sel) begin
      p_q[pp_rd] <= wb_val;
    end
  end

  // Result register: a waiting result does not hold up the controller's next load
  // once it has been taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.status     <= cmd_i.status;
      out_q.estimate_0 <= sat_32(XW'(x_q[0]));
      out_q.estimate_1 <= sat_32(XW'(x_q[1]));
      out_q.estimate_2 <= sat_32(XW'(x_q[2]));
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;
  assign sts_o.mode      = in_q.mode;
  assign sts_o.s_zero    = (s_q == 32'sd0);
  assign sts_o.div_done  = div_done;
  assign sts_o.out_busy  = out_valid_q & out_stall_i;

endmodule

/* hdl/kf3_ctrl.sv */
// Controller: sequences the dot products, divisions and result transfer.
module kf3_ctrl
  import kf3_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  kf3_sts_t sts_i,
  output kf3_cmd_t cmd_o
);

  kf3_state_e state_q, state_d;
  phase_e     phase_q, phase_d;
  logic [1:0] i_q, i_d;
  logic [1:0] j_q, j_d;
  logic [1:0] k_q, k_d;
  logic       dsel_q, dsel_d;
  status_e    status_q, status_d;
  logic       init_q, init_d;
  logic       phase_done;

  // State and loop counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      phase_q  <= PH_XP;
      i_q      <= '0;
      j_q      <= '0;
      k_q      <= '0;
      dsel_q   <= 1'b0;
      status_q <= ST_OK;
      init_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      i_q      <= i_d;
      j_q      <= j_d;
      k_q      <= k_d;
      dsel_q   <= dsel_d;
      status_q <= status_d;
      init_q   <= init_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    i_d        = i_q;
    j_d        = j_q;
    k_d        = k_q;
    dsel_d     = dsel_q;
    status_d   = status_q;
    init_d     = init_q;
    phase_done = 1'b0;
    in_stall_o = 1'b1;
    cmd_o         = '0;
    cmd_o.phase   = phase_q;
    cmd_o.i       = i_q;
    cmd_o.j       = j_q;
    cmd_o.k       = k_q;
    cmd_o.div_sel = dsel_q;
    cmd_o.status  = status_q;

    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end

      S_DECODE: begin
        status_d = ST_OK;
        i_d      = '0;
        j_d      = '0;
        k_d      = '0;
        unique case (sts_i.mode) inside
          MODE_PREDICT, MODE_CORRECT: begin
            if (!init_q) begin
              status_d = ST_NOT_INIT;
              state_d  = S_FIN;
            end else begin
              phase_d = PH_XP;
              state_d = S_MAC;
            end
          end
          MODE_INIT_VALUES, MODE_INIT_ZERO: begin
            cmd_o.simple = 1'b1;
            init_d       = 1'b1;
            state_d      = S_FIN;
          end
          MODE_SET_THIRD, MODE_BASE: begin
            cmd_o.simple = 1'b1;
            state_d      = S_FIN;
          end
          default: state_d = S_FIN;
        endcase
      end

      // One term per cycle; the datapath registers each product first and then stores a finished sum.
      S_MAC: begin
        cmd_o.mac   = 1'b1;
        cmd_o.first = (k_q == 2'd0);
        cmd_o.last  = (k_q == 2'd2);
        if (k_q != 2'd2) begin
          k_d = k_q + 2'd1;
        end else begin
          k_d = '0;
          if (phase_q == PH_S || phase_q == PH_HX) begin
            phase_done = 1'b1;
          end else if (phase_q == PH_T || phase_q == PH_PP) begin
            if (j_q != 2'd2) begin
              j_d = j_q + 2'd1;
            end else begin
              j_d = '0;
              if (i_q != 2'd2) i_d = i_q + 2'd1;
              else phase_done = 1'b1;
            end
          end else if (i_q != 2'd2) begin
            i_d = i_q + 2'd1;
          end else begin
            phase_done = 1'b1;
          end
          if (phase_done) begin
            i_d = '0;
            j_d = '0;
            if (phase_q == PH_HX || sts_i.mode == MODE_PREDICT) begin
              state_d = S_DRAIN;
            end else begin
              unique case (phase_q)
                PH_XP:   phase_d = PH_T;
                PH_T:    phase_d = PH_PP;
                PH_PP:   phase_d = PH_V;
                PH_V:    phase_d = PH_U;
                PH_U:    phase_d = PH_S;
                PH_S:    phase_d = PH_HX;
                default: phase_d = PH_XP;
              endcase
            end
          end
        end
      end

      S_DRAIN: begin
        state_d = (sts_i.mode == MODE_PREDICT) ? S_COMMIT : S_CHECK;
      end

      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = S_FIN;
      end

      S_CHECK: begin
        cmd_o.calc_e = 1'b1;
        dsel_d       = 1'b0;
        i_d          = '0;
        j_d          = '0;
        if (sts_i.s_zero) begin
          status_d = ST_SINGULAR;
          state_d  = S_FIN;
        end else begin
          state_d = S_DMUL;
        end
      end

      S_DMUL: begin
        cmd_o.div_mul = 1'b1;
        state_d       = S_DSTART;
      end

      S_DSTART: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DWAIT;
      end

      S_DWAIT: begin
        if (sts_i.div_done) state_d = S_DWB;
      end

      // State entries first, then the covariance row by row.
      S_DWB: begin
        cmd_o.div_wb = 1'b1;
        state_d      = S_DMUL;
        if (!dsel_q) begin
          if (i_q != 2'd2) begin
            i_d = i_q + 2'd1;
          end else begin
            i_d    = '0;
            dsel_d = 1'b1;
          end
        end else if (j_q != 2'd2) begin
          j_d = j_q + 2'd1;
        end else begin
          j_d = '0;
          if (i_q != 2'd2) begin
            i_d = i_q + 2'd1;
          end else begin
            i_d     = '0;
            state_d = S_FIN;
          end
        end
      end

      S_FIN: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  a_mac_needs_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MAC) |-> init_q)
    else $error("filter arithmetic started before initialisation");

  a_singular_from_correct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && status_q == ST_SINGULAR) |-> (sts_i.mode == MODE_CORRECT))
    else $error("singular status outside a correction");

  a_wb_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DWB) |-> $past(sts_i.div_done))
    else $error("write-back without a finished division");
`endif

endmodule

/* hdl/kalman_filter_three_state_top.sv */
// Top level of the three-state Kalman filter with a scalar measurement.
//
// The block takes one item at a time and returns one result per item. A
// predict-and-correct item runs 87 multiply-accumulate terms on the 16 by
// max(STATE_WIDTH, 32) bit multiplier for the prediction, covariance and
// innovation terms, then twelve divisions on the one-bit-per-cycle 64 by 32
// bit divider. A predict-only item runs the prediction terms alone; every
// other item uses neither the multiplier nor the divider. A
// finished result sits in an output register, so the next item is taken while
// that result waits for its transfer. The covariance has no defined value
// until an initialise item loads it.
module kalman_filter_three_state_top
  import kf3_pkg::*;
#(
  parameter int STATE_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  kf3_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output kf3_out_t            out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  kf3_cmd_t cmd;
  kf3_sts_t sts;

  kf3_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  kf3_dp #(
    .STATE_WIDTH (STATE_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

`ifndef ASSERT_OFF
  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second input transfer while an item is in progress");
`endif

endmodule
